FILE: sv/scc_pkg.sv
// Shared types and constants of the sector cache second-chance unit.
// Used by the slot evaluation unit, the top level and the testbench.
// Depends on nothing.
package scc_pkg;

   localparam int TAG_W       = 32;
   localparam int OP_W        = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int MAX_RESULTS = 64;
   localparam int FOUND_W     = 7;

   localparam logic [OP_W-1:0] OP_ACCESS      = 2'd0;
   localparam logic [OP_W-1:0] OP_FLUSH       = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH_EMPTY = 2'd2;

   // One row of the slot RAM: cached sector plus its policy bits.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             referenced;
      logic             dirty;
   } row_type;

   // What the evaluation unit reports about the row under inspection.
   typedef struct packed {
      logic             match;
      logic             referenced;
      logic             dirty;
      logic [TAG_W-1:0] wb_sector;
   } eval_type;

endpackage

FILE: sv/scc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; the unit holds its slot rows in one instance of it.
module scc_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/scc_slot_eval.sv
// Shared slot evaluation unit: tag compare and policy bit decode of one row.
// Depends on scc_pkg for the row and result types.
module scc_slot_eval (
   input  scc_pkg::row_type            row_in,
   input  logic [scc_pkg::TAG_W-1:0]   sector,
   output scc_pkg::eval_type           eval_out
);

   always_comb begin
      eval_out.match      = (row_in.tag == sector);
      eval_out.referenced = row_in.referenced;
      eval_out.dirty      = row_in.dirty;
      // A clean victim reports a zero sector.
      eval_out.wb_sector  = row_in.dirty ? row_in.tag : '0;
   end

endmodule

FILE: sv/sector_cache_second_chance_unit.sv
// Top level of the sector cache second-chance unit: sequencer around the slot
// RAM and the shared evaluation unit. Depends on scc_pkg, scc_ram, scc_slot_eval.
//
// A request is transferred when start is high and busy is low; busy then stays
// high until every result of that request has been issued. Results appear for
// exactly one cycle each, marked by rsp_valid, and cannot be held off, so the
// receiver must take every result in the cycle in which it is shown. One slot
// row is inspected per clock cycle through the single read port of the slot
// RAM, and that scan sets the request time. An access that hits stops at the
// matching slot; a miss scans all filled slots. When the cache is full a miss
// continues with the second-chance victim scan, which runs at most two passes
// and stops at slot 0 of the second pass at the latest. A flush scans the
// filled slots and issues at most one result per cycle. No clearing pass is
// needed after reset: slots at or above the filled count are never read.
module sector_cache_second_chance_unit #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [scc_pkg::OP_W-1:0]            req_op,
   input  logic [scc_pkg::TAG_W-1:0]           req_sector,
   input  logic                                req_make_dirty,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [scc_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   output logic                                rsp_fill_needed,
   output logic                                rsp_writeback_valid,
   output logic [scc_pkg::TAG_W-1:0]           rsp_writeback_sector,
   output logic                                rsp_last
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int ROW_W  = $bits(scc_pkg::row_type);
   localparam int EXT_W  = SLOT_W + scc_pkg::SLOT_OUT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_VICTIM,
      ST_FLUSH,
      ST_FLUSH_END
   } state_type;

   // Sequencer state and the request held while it is being served.
   state_type                      state_ff, state_in;
   logic [scc_pkg::OP_W-1:0]       op_ff, op_in;
   logic [scc_pkg::TAG_W-1:0]      sector_ff, sector_in;
   logic                           make_dirty_ff, make_dirty_in;
   logic [CNT_W-1:0]               filled_ff, filled_in;

   // Scan pipeline: issue_ff addresses the RAM, chk_* tags the row that returns.
   logic [CNT_W-1:0]               issue_ff, issue_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0]              chk_idx_ff, chk_idx_in;

   // Flush bookkeeping: one dirty slot is held back so that the final result
   // of a flush can carry the last flag.
   logic [scc_pkg::FOUND_W-1:0]    found_ff, found_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]              pend_slot_ff, pend_slot_in;
   logic [scc_pkg::TAG_W-1:0]      pend_sector_ff, pend_sector_in;

   // Result registers.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [scc_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                           rsp_fill_ff, rsp_fill_in;
   logic                           rsp_wbv_ff, rsp_wbv_in;
   logic [scc_pkg::TAG_W-1:0]      rsp_wbs_ff, rsp_wbs_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Slot RAM ports and the evaluation of the returned row.
   logic                           ram_wr_en;
   logic [SLOT_W-1:0]              ram_wr_addr;
   scc_pkg::row_type               ram_wr_data;
   logic [ROW_W-1:0]               ram_rd_data;
   scc_pkg::row_type               rd_row;
   scc_pkg::eval_type              eval;

   // Slot indices widened so that the low six bits can be reported.
   logic [EXT_W-1:0]               chk_ext;
   logic [EXT_W-1:0]               fill_ext;
   logic [EXT_W-1:0]               pend_ext;

   assign rd_row   = scc_pkg::row_type'(ram_rd_data);
   assign chk_ext  = {{scc_pkg::SLOT_OUT_W{1'b0}}, chk_idx_ff};
   assign fill_ext = {{scc_pkg::SLOT_OUT_W{1'b0}}, filled_ff[SLOT_W-1:0]};
   assign pend_ext = {{scc_pkg::SLOT_OUT_W{1'b0}}, pend_slot_ff};

   scc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   scc_slot_eval u_eval (
      .row_in   (rd_row),
      .sector   (sector_ff),
      .eval_out (eval)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      sector_in      = sector_ff;
      make_dirty_in  = make_dirty_ff;
      filled_in      = filled_ff;
      issue_in       = issue_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_sector_in = pend_sector_ff;

      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_wbv_in     = rsp_wbv_ff;
      rsp_wbs_in     = rsp_wbs_ff;
      rsp_last_in    = rsp_last_ff;

      ram_wr_en      = 1'b0;
      ram_wr_addr    = chk_idx_ff;
      ram_wr_data    = rd_row;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_op;
               sector_in     = req_sector;
               make_dirty_in = req_make_dirty;
               issue_in      = '0;
               found_in      = '0;
               pend_valid_in = 1'b0;
               unique case (req_op)
                  scc_pkg::OP_ACCESS:      state_in = ST_LOOKUP;
                  scc_pkg::OP_FLUSH,
                  scc_pkg::OP_FLUSH_EMPTY: state_in = ST_FLUSH;
                  default:                 state_in = ST_IDLE;
               endcase
            end
         end

         ST_LOOKUP: begin
            if (issue_ff < filled_ff) begin
               issue_in     = issue_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[SLOT_W-1:0];
            end
            if (chk_valid_ff) begin
               if (eval.match) begin
                  // Hit: mark referenced and fold in the write flag.
                  ram_wr_en              = 1'b1;
                  ram_wr_data.referenced = 1'b1;
                  ram_wr_data.dirty      = rd_row.dirty | make_dirty_ff;
                  rsp_valid_in           = 1'b1;
                  rsp_hit_in             = 1'b1;
                  rsp_slot_in            = chk_ext[scc_pkg::SLOT_OUT_W-1:0];
                  rsp_fill_in            = 1'b0;
                  rsp_wbv_in             = 1'b0;
                  rsp_wbs_in             = '0;
                  rsp_last_in            = 1'b1;
                  state_in               = ST_IDLE;
               end
            end else if (issue_ff == filled_ff) begin
               if (filled_ff < CNT_W'(NUM_SLOTS)) begin
                  // Miss with a free slot: take the next one in order.
                  ram_wr_en              = 1'b1;
                  ram_wr_addr            = filled_ff[SLOT_W-1:0];
                  ram_wr_data.tag        = sector_ff;
                  ram_wr_data.referenced = 1'b1;
                  ram_wr_data.dirty      = make_dirty_ff;
                  filled_in              = filled_ff + CNT_W'(1);
                  rsp_valid_in           = 1'b1;
                  rsp_hit_in             = 1'b0;
                  rsp_slot_in            = fill_ext[scc_pkg::SLOT_OUT_W-1:0];
                  rsp_fill_in            = 1'b1;
                  rsp_wbv_in             = 1'b0;
                  rsp_wbs_in             = '0;
                  rsp_last_in            = 1'b1;
                  state_in               = ST_IDLE;
               end else begin
                  issue_in = '0;
                  state_in = ST_VICTIM;
               end
            end
         end

         ST_VICTIM: begin
            // The scan wraps round; after one pass every reference bit is clear.
            if (issue_ff == CNT_W'(NUM_SLOTS - 1)) begin
               issue_in = '0;
            end else begin
               issue_in = issue_ff + CNT_W'(1);
            end
            chk_valid_in = 1'b1;
            chk_idx_in   = issue_ff[SLOT_W-1:0];
            if (chk_valid_ff) begin
               ram_wr_en = 1'b1;
               if (eval.referenced) begin
                  ram_wr_data.referenced = 1'b0;
               end else begin
                  ram_wr_data.tag        = sector_ff;
                  ram_wr_data.referenced = 1'b1;
                  ram_wr_data.dirty      = make_dirty_ff;
                  rsp_valid_in           = 1'b1;
                  rsp_hit_in             = 1'b0;
                  rsp_slot_in            = chk_ext[scc_pkg::SLOT_OUT_W-1:0];
                  rsp_fill_in            = 1'b1;
                  rsp_wbv_in             = eval.dirty;
                  rsp_wbs_in             = eval.wb_sector;
                  rsp_last_in            = 1'b1;
                  state_in               = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (issue_ff < filled_ff) begin
               issue_in     = issue_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[SLOT_W-1:0];
            end
            if (chk_valid_ff) begin
               if (eval.dirty) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_data.dirty = 1'b0;
                  // The slot held back so far is now known not to be the last.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b0;
                     rsp_slot_in  = pend_ext[scc_pkg::SLOT_OUT_W-1:0];
                     rsp_fill_in  = 1'b0;
                     rsp_wbv_in   = 1'b1;
                     rsp_wbs_in   = pend_sector_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_slot_in   = chk_idx_ff;
                  pend_sector_in = rd_row.tag;
                  found_in       = found_ff + scc_pkg::FOUND_W'(1);
                  if (found_in == scc_pkg::FOUND_W'(scc_pkg::MAX_RESULTS)) begin
                     state_in = ST_FLUSH_END;
                  end
               end
            end else if (issue_ff == filled_ff) begin
               state_in = ST_FLUSH_END;
            end
         end

         ST_FLUSH_END: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_slot_in  = pend_ext[scc_pkg::SLOT_OUT_W-1:0];
               rsp_fill_in  = 1'b0;
               rsp_wbv_in   = 1'b1;
               rsp_wbs_in   = pend_sector_ff;
               rsp_last_in  = 1'b1;
            end
            pend_valid_in = 1'b0;
            if (op_ff == scc_pkg::OP_FLUSH_EMPTY) begin
               filled_in = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         filled_ff     <= '0;
         issue_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         found_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         filled_ff     <= filled_in;
         issue_ff      <= issue_in;
         chk_valid_ff  <= chk_valid_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      sector_ff      <= sector_in;
      make_dirty_ff  <= make_dirty_in;
      chk_idx_ff     <= chk_idx_in;
      pend_slot_ff   <= pend_slot_in;
      pend_sector_ff <= pend_sector_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_wbv_ff     <= rsp_wbv_in;
      rsp_wbs_ff     <= rsp_wbs_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_fill_needed      = rsp_fill_ff;
   assign rsp_writeback_valid  = rsp_wbv_ff;
   assign rsp_writeback_sector = rsp_wbs_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

FILE: test/sector_cache_second_chance_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sector_cache_second_chance_unit: directed and random cache
// requests, with results checked against a behavioural model of tags and second chance.
// Depends on scc_pkg and the RTL of the unit.
module testbench;

   localparam int SLOTS          = 64;
   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 470;
   localparam int POOL_SIZE      = 80;
   localparam int REPORT_LIMIT   = 10;
   // Longest request is a full-cache miss whose victim scan runs two passes.
   localparam int TAIL_CYCLES    = 3 * SLOTS + 16;
   localparam int WATCHDOG_LIMIT = 5000;

   // The sender's idle rate, in percent, over the three thirds of the random part.
   localparam int GAP_LIGHT = 8;
   localparam int GAP_HEAVY = 81;
   localparam int GAP_NONE  = 0;

   // The unused op code: the unit must ignore it.
   localparam logic [scc_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

   typedef struct {
      logic [scc_pkg::OP_W-1:0]  op;
      logic [scc_pkg::TAG_W-1:0] sector;
      logic                      make_dirty;
      bit                        drain;    // hold the request back until nothing is awaited
      int unsigned               gap_pct;  // chance of an idle cycle before it is offered
   } cache_req_type;

   typedef struct packed {
      logic                           hit;
      logic [scc_pkg::SLOT_OUT_W-1:0] slot;
      logic                           fill_needed;
      logic                           wb_valid;
      logic [scc_pkg::TAG_W-1:0]      wb_sector;
      logic                           last;
   } cache_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [scc_pkg::OP_W-1:0]       req_op = scc_pkg::OP_ACCESS;
   logic [scc_pkg::TAG_W-1:0]      req_sector = '0;
   logic                           req_make_dirty = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_hit;
   logic [scc_pkg::SLOT_OUT_W-1:0] rsp_slot;
   logic                           rsp_fill_needed;
   logic                           rsp_writeback_valid;
   logic [scc_pkg::TAG_W-1:0]      rsp_writeback_sector;
   logic                           rsp_last;

   // Set at a rising edge at which the request on the ports was transferred.
   logic req_taken = 1'b0;

   cache_req_type request_queue[$];
   cache_rsp_type awaited_results[$];
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;

   // Behavioural copy of the cache state.
   logic [scc_pkg::TAG_W-1:0] cache_tag   [SLOTS];
   logic                      cache_ref   [SLOTS];
   logic                      cache_dirty [SLOTS];
   int unsigned               cache_filled;

   sector_cache_second_chance_unit #(
      .NUM_SLOTS(SLOTS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_sector           (req_sector),
      .req_make_dirty       (req_make_dirty),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_fill_needed      (rsp_fill_needed),
      .rsp_writeback_valid  (rsp_writeback_valid),
      .rsp_writeback_sector (rsp_writeback_sector),
      .rsp_last             (rsp_last)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Works out the results of one transferred request and updates the model state.
   // An access yields exactly one result; a flush yields one per dirty slot, with last
   // raised only on the final one, and nothing at all when no slot is dirty.
   function automatic void predict_cache_outcome(logic [scc_pkg::OP_W-1:0] op,
                                                 logic [scc_pkg::TAG_W-1:0] sector,
                                                 logic make_dirty);
      cache_rsp_type outcome;
      bit            found;
      int unsigned   way;
      int unsigned   dirty_total;
      int unsigned   emitted;

      found = 1'b0;
      way = 0;
      if (op == scc_pkg::OP_ACCESS) begin
         // The lowest matching filled slot wins, should a tag ever appear twice.
         for (int i = 0; i < cache_filled; i++) begin
            if (!found && cache_tag[i] == sector) begin
               found = 1'b1;
               way = i;
            end
         end
         outcome = '0;
         outcome.last = 1'b1;
         if (found) begin
            cache_ref[way] = 1'b1;
            cache_dirty[way] = cache_dirty[way] | make_dirty;
            outcome.hit = 1'b1;
            outcome.slot = way[scc_pkg::SLOT_OUT_W-1:0];
         end else begin
            if (cache_filled < SLOTS) begin
               way = cache_filled;
               cache_filled++;
            end else begin
               // Second chance: referenced slots lose their bit and are passed over.
               // One pass clears every bit, so the second pass stops at slot 0.
               for (int pass = 0; pass < 2; pass++) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!found) begin
                        if (cache_ref[i]) begin
                           cache_ref[i] = 1'b0;
                        end else begin
                           found = 1'b1;
                           way = i;
                        end
                     end
                  end
               end
               if (cache_dirty[way]) begin
                  outcome.wb_valid = 1'b1;
                  outcome.wb_sector = cache_tag[way];
               end
            end
            cache_tag[way] = sector;
            cache_ref[way] = 1'b1;
            cache_dirty[way] = make_dirty;
            outcome.slot = way[scc_pkg::SLOT_OUT_W-1:0];
            outcome.fill_needed = 1'b1;
         end
         awaited_results.push_back(outcome);
      end else if (op == scc_pkg::OP_FLUSH || op == scc_pkg::OP_FLUSH_EMPTY) begin
         dirty_total = 0;
         for (int i = 0; i < cache_filled; i++) begin
            if (cache_dirty[i] && dirty_total < scc_pkg::MAX_RESULTS) begin
               dirty_total++;
            end
         end
         emitted = 0;
         for (int i = 0; i < cache_filled; i++) begin
            if (cache_dirty[i] && emitted < dirty_total) begin
               cache_dirty[i] = 1'b0;
               outcome = '0;
               outcome.slot = i[scc_pkg::SLOT_OUT_W-1:0];
               outcome.wb_valid = 1'b1;
               outcome.wb_sector = cache_tag[i];
               outcome.last = (emitted == dirty_total - 1);
               awaited_results.push_back(outcome);
               emitted++;
            end
         end
         if (op == scc_pkg::OP_FLUSH_EMPTY) begin
            for (int i = 0; i < SLOTS; i++) begin
               cache_ref[i] = 1'b0;
               cache_dirty[i] = 1'b0;
            end
            cache_filled = 0;
         end
      end
   endfunction

   // Compares one result from the unit with the oldest awaited one.
   function automatic void check_cache_result(cache_rsp_type seen);
      cache_rsp_type wanted;

      if (awaited_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result with nothing awaited: hit=%0b slot=%0d fill=%0b wb=%0b %h last=%0b",
                     $realtime, seen.hit, seen.slot, seen.fill_needed, seen.wb_valid,
                     seen.wb_sector, seen.last);
         end
         return;
      end
      wanted = awaited_results.pop_front();
      if (seen.hit !== wanted.hit || seen.slot !== wanted.slot
          || seen.fill_needed !== wanted.fill_needed || seen.wb_valid !== wanted.wb_valid
          || seen.wb_sector !== wanted.wb_sector || seen.last !== wanted.last) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected hit=%0b slot=%0d fill=%0b wb=%0b %h last=%0b",
                     $realtime, wanted.hit, wanted.slot, wanted.fill_needed, wanted.wb_valid,
                     wanted.wb_sector, wanted.last);
            $display("%0t: actual   hit=%0b slot=%0d fill=%0b wb=%0b %h last=%0b",
                     $realtime, seen.hit, seen.slot, seen.fill_needed, seen.wb_valid,
                     seen.wb_sector, seen.last);
         end
      end
   endfunction

   task automatic add_request(logic [scc_pkg::OP_W-1:0] op, logic [scc_pkg::TAG_W-1:0] sector,
                              logic make_dirty, bit drain, int unsigned gap_pct);
      cache_req_type entry;

      entry.op = op;
      entry.sector = sector;
      entry.make_dirty = make_dirty;
      entry.drain = drain;
      entry.gap_pct = gap_pct;
      request_queue.push_back(entry);
   endtask

   // Driver: inputs change at the falling edge only. A new request is offered once the
   // previous one has been transferred; start stays high while busy holds it off.
   always @(negedge clock) begin
      cache_req_type next_req;

      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (request_queue.size() == 0) begin
            start <= 1'b0;
         end else if (request_queue[0].drain && awaited_results.size() != 0) begin
            start <= 1'b0;
         end else if ($urandom_range(99) < request_queue[0].gap_pct) begin
            start <= 1'b0;
         end else begin
            next_req = request_queue.pop_front();
            req_op <= next_req.op;
            req_sector <= next_req.sector;
            req_make_dirty <= next_req.make_dirty;
            start <= 1'b1;
         end
      end
   end

   // Monitor: everything is sampled at the rising edge. Results are checked before the
   // request transferred at the same edge is predicted, which keeps the order of the
   // awaited results the order in which the unit must issue them.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            check_cache_result({rsp_hit, rsp_slot, rsp_fill_needed, rsp_writeback_valid,
                                rsp_writeback_sector, rsp_last});
         end
         if (start && !busy) begin
            predict_cache_outcome(req_op, req_sector, req_make_dirty);
         end
      end
   end

   // Watchdog: a long run of cycles with neither a request nor a result transfer means
   // the unit has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sector_cache_second_chance_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [scc_pkg::TAG_W-1:0] sector_pool[POOL_SIZE];
      logic [scc_pkg::TAG_W-1:0] sector;
      logic [scc_pkg::OP_W-1:0]  op;
      int unsigned               counted;
      int unsigned               gap;
      int unsigned               pick;
      bit                        drain;

      for (int i = 0; i < SLOTS; i++) begin
         cache_tag[i] = '0;
         cache_ref[i] = 1'b0;
         cache_dirty[i] = 1'b0;
      end
      cache_filled = 0;

      // Directed part: flushes of an empty cache, the ignored op code, the extreme
      // sectors, hits that set and that keep the dirty flag, a flush with several
      // dirty slots, a repeated flush with nothing to write back, and an emptying
      // flush followed by an access that must land in slot 0 again.
      add_request(scc_pkg::OP_FLUSH,       '0,            1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_FLUSH_EMPTY, '1,            1'b1, 1'b0, GAP_LIGHT);
      add_request(OP_RESERVED,             '1,            1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      '0,            1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      '1,            1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      '0,            1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      '1,            1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'h8000_0000, 1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'h0000_0001, 1'b1, 1'b0, GAP_LIGHT);
      add_request(OP_RESERVED,             '0,            1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'hAAAA_AAAA, 1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'h5555_5555, 1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_FLUSH,       $urandom,      1'b1, 1'b1, GAP_LIGHT);
      add_request(scc_pkg::OP_FLUSH,       $urandom,      1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'h0000_0001, 1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      $urandom,      1'b1, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_FLUSH_EMPTY, $urandom,      1'b0, 1'b1, GAP_LIGHT);
      add_request(scc_pkg::OP_ACCESS,      32'h0000_0001, 1'b0, 1'b0, GAP_LIGHT);
      add_request(scc_pkg::OP_FLUSH_EMPTY, '0,            1'b0, 1'b0, GAP_LIGHT);

      // Random part: mostly accesses drawn from a pool somewhat larger than the cache,
      // so that it fills, hits often and keeps evicting, plus fresh sectors that always
      // miss. Emptying flushes are held back early on so that the full-cache victim scan
      // gets plenty of exercise.
      sector_pool[0] = '0;
      sector_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         sector_pool[i] = $urandom;
      end
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted < RANDOM_ITEMS / 3) begin
            gap = GAP_LIGHT;
         end else if (counted < 2 * RANDOM_ITEMS / 3) begin
            gap = GAP_HEAVY;
         end else begin
            gap = GAP_NONE;
         end
         pick = $urandom_range(99);
         drain = ($urandom_range(99) < 3);
         sector = $urandom;
         if (counted == 2 * RANDOM_ITEMS / 3) begin
            op = scc_pkg::OP_FLUSH_EMPTY;
            drain = 1'b1;
         end else if (pick < 2) begin
            op = OP_RESERVED;
         end else if (pick < 6) begin
            op = scc_pkg::OP_FLUSH;
         end else if (pick < 7 && counted > 150) begin
            op = scc_pkg::OP_FLUSH_EMPTY;
         end else begin
            op = scc_pkg::OP_ACCESS;
            if ($urandom_range(99) < 70) begin
               sector = sector_pool[$urandom_range(POOL_SIZE - 1)];
            end
         end
         add_request(op, sector, $urandom_range(1), drain, gap);
         if (op != OP_RESERVED) begin
            counted++;
         end
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Let every request go out, every awaited result arrive, then give the unit time
      // to show any stray result before deciding.
      while (request_queue.size() != 0 || start) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("sector_cache_second_chance_unit verification clean");
      end else begin
         $display("sector_cache_second_chance_unit verification failed");
      end
      $finish;
   end

endmodule
